[rtl/core/spz_pkg.sv]
// shared types and constants for the sponge core
`timescale 1ns / 1ps

package spz_pkg;

  // update steps in one shuffle (a single whip)
  localparam int unsigned WHIP_ROUNDS = 512;
  localparam int unsigned RoundW      = $clog2(WHIP_ROUNDS + 1);

  // absorb midpoint, nibble area base and whip step increment
  localparam logic [7:0] HalfIdx = 8'd128;
  localparam logic [7:0] StepInc = 8'd2;
  localparam logic [7:0] StepRst = 8'd1;

  // request codes
  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_ABSORB = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_DRIP   = 2'd3
  } req_e;

  // access to the permutation store
  typedef struct packed {
    logic       clr;
    logic       rd_en;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
  } perm_req_t;

endpackage

[rtl/core/spz_if.sv]
// request and result channel interfaces of the sponge core
`timescale 1ns / 1ps

interface spz_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface spz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

[rtl/core/spz_perm_store.sv]
// 256 x 8 permutation store with per-entry valid bits, unwritten entries read as identity
`timescale 1ns / 1ps

module spz_perm_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spz_pkg::perm_req_t   acc_i,
  output logic [7:0]           rdata_o
);
  import spz_pkg::*;

  logic [7:0]   mem_q [256];
  logic [255:0] vld_q;
  logic [7:0]   rdata_q;
  logic [7:0]   raddr_q;
  logic         rvld_q;

  // storage array, read data registered
  always_ff @(posedge clk_i) begin
    if (acc_i.wr_en) begin
      mem_q[acc_i.wr_addr] <= acc_i.wr_data;
    end
    if (acc_i.rd_en) begin
      rdata_q <= mem_q[acc_i.rd_addr];
      raddr_q <= acc_i.rd_addr;
    end
  end

  // valid bits, cleared by reset and by initialize
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (acc_i.clr) begin
        vld_q <= '0;
      end else if (acc_i.wr_en) begin
        vld_q[acc_i.wr_addr] <= 1'b1;
      end
      if (acc_i.rd_en) begin
        rvld_q <= vld_q[acc_i.rd_addr];
      end
    end
  end

  // never written entry holds its own index
  assign rdata_o = rvld_q ? rdata_q : raddr_q;

endmodule

[rtl/core/spritz_sponge_core.sv]
// Sponge core over a 256-byte permutation with a sequencer around one read/write store.
// One item at a time; the request channel is ready only while the sequencer is idle.
// All table traffic goes through a single store with one registered read and one write
// per cycle. Absorbing a byte takes two nibble swaps plus dispatch; a drip takes one
// update step, the output step and dispatch. A shuffle of WHIP_ROUNDS update steps
// (512) runs when the absorb count reaches 128 or before a drip that follows absorption.
// A finished byte waits in the output register while the next item is taken; a second
// drip holds at its end until that register is free.
`timescale 1ns / 1ps

module spritz_sponge_core (
  input  logic clk_i,
  input  logic rst_ni,
  spz_req_if.sink   req_i,
  spz_out_if.source res_o
);
  import spz_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS_CHK,
    ST_ABS_R0,
    ST_ABS_R1,
    ST_ABS_W0,
    ST_ABS_W1,
    ST_STOP_CHK,
    ST_DRIP_CHK,
    ST_UPD0,
    ST_UPD1,
    ST_UPD2,
    ST_UPD3,
    ST_UPD4,
    ST_OUT0,
    ST_OUT1,
    ST_OUT2
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] i_q, i_d;
  logic [7:0] j_q, j_d;
  logic [7:0] k_q, k_d;
  logic [7:0] w_q, w_d;
  logic [7:0] last_q, last_d;
  logic [7:0] byte_q, byte_d;
  logic [7:0] tmp_q, tmp_d;
  logic       nib_hi_q, nib_hi_d;
  logic       shuf_q, shuf_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_q, out_d;

  perm_req_t  acc;
  logic [7:0] rd;
  logic [3:0] nib;
  logic [7:0] nib_addr;

  spz_perm_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .rdata_o (rd)
  );

  assign nib      = nib_hi_q ? byte_q[7:4] : byte_q[3:0];
  assign nib_addr = HalfIdx + {4'd0, nib};

  assign req_i.ready    = (state_q == ST_IDLE);
  assign res_o.valid    = out_vld_q;
  assign res_o.out_byte = out_q;

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    w_d       = w_q;
    last_d    = last_q;
    byte_d    = byte_q;
    tmp_d     = tmp_q;
    nib_hi_d  = nib_hi_q;
    shuf_d    = shuf_q;
    rnd_d     = rnd_q;
    out_vld_d = out_vld_q && !res_o.ready;
    out_d     = out_q;
    acc       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          byte_d   = req_i.data_byte;
          nib_hi_d = 1'b0;
          unique case (req_e'(req_i.req_type))
            REQ_INIT: begin
              cnt_d   = '0;
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              w_d     = StepRst;
              last_d  = '0;
              acc.clr = 1'b1;
            end
            REQ_ABSORB: state_d = ST_ABS_CHK;
            REQ_STOP:   state_d = ST_STOP_CHK;
            REQ_DRIP:   state_d = ST_DRIP_CHK;
            default:    state_d = ST_IDLE;
          endcase
        end
      end

      // absorb one nibble, shuffle first at the midpoint
      ST_ABS_CHK: begin
        if (cnt_q == HalfIdx) begin
          shuf_d  = 1'b1;
          rnd_d   = '0;
          ret_d   = ST_ABS_CHK;
          state_d = ST_UPD0;
        end else begin
          state_d = ST_ABS_R0;
        end
      end
      ST_ABS_R0: begin
        acc.rd_en   = 1'b1;
        acc.rd_addr = cnt_q;
        state_d     = ST_ABS_R1;
      end
      ST_ABS_R1: begin
        tmp_d       = rd;
        acc.rd_en   = 1'b1;
        acc.rd_addr = nib_addr;
        state_d     = ST_ABS_W0;
      end
      ST_ABS_W0: begin
        acc.wr_en   = 1'b1;
        acc.wr_addr = cnt_q;
        acc.wr_data = rd;
        state_d     = ST_ABS_W1;
      end
      ST_ABS_W1: begin
        acc.wr_en   = 1'b1;
        acc.wr_addr = nib_addr;
        acc.wr_data = tmp_q;
        cnt_d       = cnt_q + 8'd1;
        if (nib_hi_q) begin
          state_d = ST_IDLE;
        end else begin
          nib_hi_d = 1'b1;
          state_d  = ST_ABS_CHK;
        end
      end

      // absorb stop
      ST_STOP_CHK: begin
        if (cnt_q == HalfIdx) begin
          shuf_d  = 1'b1;
          rnd_d   = '0;
          ret_d   = ST_STOP_CHK;
          state_d = ST_UPD0;
        end else begin
          cnt_d   = cnt_q + 8'd1;
          state_d = ST_IDLE;
        end
      end

      // drip: shuffle after absorption, then one update and the output step
      ST_DRIP_CHK: begin
        state_d = ST_UPD0;
        if (cnt_q != 8'd0) begin
          shuf_d = 1'b1;
          rnd_d  = '0;
          ret_d  = ST_DRIP_CHK;
        end else begin
          shuf_d = 1'b0;
          ret_d  = ST_OUT0;
        end
      end

      // update step
      ST_UPD0: begin
        i_d         = i_q + w_q;
        acc.rd_en   = 1'b1;
        acc.rd_addr = i_q + w_q;
        state_d     = ST_UPD1;
      end
      ST_UPD1: begin
        tmp_d       = rd;
        acc.rd_en   = 1'b1;
        acc.rd_addr = j_q + rd;
        state_d     = ST_UPD2;
      end
      ST_UPD2: begin
        j_d         = k_q + rd;
        acc.rd_en   = 1'b1;
        acc.rd_addr = k_q + rd;
        state_d     = ST_UPD3;
      end
      ST_UPD3: begin
        k_d         = i_q + k_q + rd;
        acc.wr_en   = 1'b1;
        acc.wr_addr = i_q;
        acc.wr_data = rd;
        state_d     = ST_UPD4;
      end
      ST_UPD4: begin
        acc.wr_en   = 1'b1;
        acc.wr_addr = j_q;
        acc.wr_data = tmp_q;
        if (!shuf_q) begin
          state_d = ret_q;
        end else if (rnd_q == RoundW'(WHIP_ROUNDS - 1)) begin
          w_d     = w_q + StepInc;
          cnt_d   = '0;
          shuf_d  = 1'b0;
          rnd_d   = '0;
          state_d = ret_q;
        end else begin
          rnd_d   = rnd_q + RoundW'(1);
          state_d = ST_UPD0;
        end
      end

      // output function
      ST_OUT0: begin
        acc.rd_en   = 1'b1;
        acc.rd_addr = last_q + k_q;
        state_d     = ST_OUT1;
      end
      ST_OUT1: begin
        acc.rd_en   = 1'b1;
        acc.rd_addr = i_q + rd;
        state_d     = ST_OUT2;
      end
      ST_OUT2: begin
        acc.rd_en   = 1'b1;
        acc.rd_addr = j_q + rd;
        ret_d       = ST_IDLE;
        // final read lands in the idle-bound hand-off below
        state_d     = ST_UPD4;
      end
      default: state_d = ST_IDLE;
    endcase

    // hand-off of the dripped byte once the output register is free
    if (state_q == ST_UPD4 && ret_q == ST_IDLE && !shuf_q) begin
      if (out_vld_q && !res_o.ready) begin
        state_d = ST_UPD4;
        acc     = '0;
      end else begin
        out_vld_d = 1'b1;
        out_d     = rd;
        last_d    = rd;
        state_d   = ST_IDLE;
        acc       = '0;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      cnt_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      w_q       <= StepRst;
      last_q    <= '0;
      nib_hi_q  <= 1'b0;
      shuf_q    <= 1'b0;
      rnd_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      cnt_q     <= cnt_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      w_q       <= w_d;
      last_q    <= last_d;
      nib_hi_q  <= nib_hi_d;
      shuf_q    <= shuf_d;
      rnd_q     <= rnd_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    tmp_q  <= tmp_d;
    out_q  <= out_d;
  end

endmodule

[rtl/core/spz_checker.sv]
// port-level checks for the sponge core and their bind
`timescale 1ns / 1ps

module spz_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_type_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i
);
  import spz_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a waiting result keeps its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i))
    else $error("result byte changed while stalled");

  // every item but initialize keeps the core busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_type_i != REQ_INIT) |=> !in_ready_i)
    else $error("core ready right after a multi-cycle item");

  // no result rises in the cycle after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result raised too early");

endmodule

bind spritz_sponge_core spz_checker u_spz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_type_i   (req_i.req_type),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_byte_i  (res_o.out_byte)
);

[tb/tb_spritz_sponge_core.sv]
// self-checking testbench for the sponge core: directed table, then random request sequences
`timescale 1ns / 1ps

module tb_spritz_sponge_core;
  import spz_pkg::*;

  // one row of the directed table; want is typed in only where pinned is set
  typedef struct {
    req_e       op;
    logic [7:0] arg;
    bit         pinned;
    logic [7:0] want;
  } dir_row_t;

  localparam int unsigned DirRows   = 25;
  localparam int unsigned ItemGoal  = 700;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned DrainWait = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  spz_req_if req_if ();
  spz_out_if res_if ();

  spritz_sponge_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the sponge state
  logic [7:0] sb [256];
  logic [7:0] sb_a, sb_i, sb_j, sb_k, sb_w, sb_z;

  // expected drip bytes, oldest first
  logic [7:0] drip_q [$];
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  bit          hold_res = 1'b0;
  bit          pin_en;
  logic [7:0]  pin_val;
  int unsigned burst_left = 0;

  dir_row_t dir_tab [DirRows] = '{
    '{REQ_DRIP,   8'h00, 1'b1, 8'd4},
    '{REQ_DRIP,   8'h00, 1'b1, 8'd20},
    '{REQ_INIT,   8'hff, 1'b0, 8'd0},
    '{REQ_DRIP,   8'hff, 1'b1, 8'd4},
    '{REQ_ABSORB, 8'h00, 1'b0, 8'd0},
    '{REQ_ABSORB, 8'hff, 1'b0, 8'd0},
    '{REQ_ABSORB, 8'h0f, 1'b0, 8'd0},
    '{REQ_ABSORB, 8'hf0, 1'b0, 8'd0},
    '{REQ_STOP,   8'h55, 1'b0, 8'd0},
    '{REQ_DRIP,   8'haa, 1'b0, 8'd0},
    '{REQ_DRIP,   8'h00, 1'b0, 8'd0},
    '{REQ_STOP,   8'h00, 1'b0, 8'd0},
    '{REQ_STOP,   8'hff, 1'b0, 8'd0},
    '{REQ_DRIP,   8'h00, 1'b0, 8'd0},
    '{REQ_INIT,   8'h00, 1'b0, 8'd0},
    '{REQ_ABSORB, 8'h80, 1'b0, 8'd0},
    '{REQ_STOP,   8'h00, 1'b0, 8'd0},
    '{REQ_ABSORB, 8'h7f, 1'b0, 8'd0},
    '{REQ_DRIP,   8'h00, 1'b0, 8'd0},
    '{REQ_INIT,   8'h00, 1'b0, 8'd0},
    '{REQ_STOP,   8'h00, 1'b0, 8'd0},
    '{REQ_DRIP,   8'h00, 1'b0, 8'd0},
    '{REQ_DRIP,   8'h00, 1'b0, 8'd0},
    '{REQ_ABSORB, 8'h01, 1'b0, 8'd0},
    '{REQ_DRIP,   8'h00, 1'b0, 8'd0}
  };

  // state after reset or initialize
  function automatic void sb_clear();
    for (int v = 0; v < 256; v++) sb[v] = v[7:0];
    sb_a = 8'd0;
    sb_i = 8'd0;
    sb_j = 8'd0;
    sb_k = 8'd0;
    sb_w = StepRst;
    sb_z = 8'd0;
  endfunction

  function automatic void sb_swap(input logic [7:0] p, input logic [7:0] q);
    logic [7:0] t;
    t     = sb[p];
    sb[p] = sb[q];
    sb[q] = t;
  endfunction

  // one update step of the permutation
  function automatic void sb_update();
    logic [7:0] y;
    sb_i = sb_i + sb_w;
    y    = sb_j + sb[sb_i];
    sb_j = sb_k + sb[y];
    sb_k = sb_i + sb_k + sb[sb_j];
    sb_swap(sb_i, sb_j);
  endfunction

  // output function, updates the last output byte
  function automatic logic [7:0] sb_out();
    logic [7:0] y1, x1, y2;
    y1   = sb_z + sb_k;
    x1   = sb_i + sb[y1];
    y2   = sb_j + sb[x1];
    sb_z = sb[y2];
    return sb_z;
  endfunction

  // shuffle is one whip, no crush
  function automatic void sb_whip();
    for (int unsigned r = 0; r < WHIP_ROUNDS; r++) sb_update();
    sb_w = sb_w + StepInc;
    sb_a = 8'd0;
  endfunction

  function automatic void sb_nibble(input logic [3:0] nib);
    if (sb_a == HalfIdx) sb_whip();
    sb_swap(sb_a, HalfIdx + {4'd0, nib});
    sb_a = sb_a + 8'd1;
  endfunction

  // next state for one request, and the drip byte if there is one
  function automatic void sponge_apply(input req_e op, input logic [7:0] arg,
                                       output bit emits, output logic [7:0] byte_o);
    emits  = 1'b0;
    byte_o = 8'd0;
    case (op)
      REQ_INIT: begin
        sb_clear();
      end
      REQ_ABSORB: begin
        sb_nibble(arg[3:0]);
        sb_nibble(arg[7:4]);
      end
      REQ_STOP: begin
        if (sb_a == HalfIdx) sb_whip();
        sb_a = sb_a + 8'd1;
      end
      default: begin
        if (sb_a != 8'd0) sb_whip();
        sb_update();
        byte_o = sb_out();
        emits  = 1'b1;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // check drip bytes, then record accepted requests
  always @(posedge clk_i) begin : mon
    logic [7:0] want;
    bit         emits;
    logic [7:0] calc;
    if (res_if.valid && res_if.ready) begin
      if (drip_q.size() == 0) begin
        flag_mismatch($sformatf("drip byte %h with none expected", res_if.out_byte));
      end else begin
        want = drip_q.pop_front();
        if (res_if.out_byte !== want)
          flag_mismatch($sformatf("out_byte got %h exp %h", res_if.out_byte, want));
      end
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      sponge_apply(req_e'(req_if.req_type), req_if.data_byte, emits, calc);
      if (emits) drip_q.push_back(pin_en ? pin_val : calc);
    end
  end

  // receiver: ready pattern in random stretches, long hold-off on request
  initial begin : rx
    int unsigned mode, left;
    res_if.ready = 1'b0;
    left = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_res) begin
        res_if.ready <= 1'b0;
        repeat (HoldLen) @(negedge clk_i);
        hold_res = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0, 1:    res_if.ready <= 1'b1;
          2:       res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // offer one item at a falling edge, wait for the handshake, then maybe a gap
  task automatic send(input req_e op, input logic [7:0] arg,
                      input bit pinned, input logic [7:0] want);
    int unsigned gap;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= op;
    req_if.data_byte <= arg;
    pin_en           <= pinned;
    pin_val          <= want;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_rand(input req_e op);
    send(op, 8'($urandom_range(0, 255)), 1'b0, 8'd0);
  endtask

  // stimulus
  initial begin : stim
    int unsigned seq, nb, choice;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_INIT;
    req_if.data_byte = 8'd0;
    pin_en           = 1'b0;
    pin_val          = 8'd0;
    sb_clear();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_tab[r]) send(dir_tab[r].op, dir_tab[r].arg, dir_tab[r].pinned, dir_tab[r].want);

    // random sequences
    seq = 0;
    while (n_sent < ItemGoal) begin
      seq++;
      choice = $urandom_range(0, 99);
      if (seq == 4 || seq == 25) begin
        // long receiver hold-off while drips keep coming, so the core backs up
        hold_res = 1'b1;
        send_rand(REQ_INIT);
        repeat (8) send_rand(REQ_DRIP);
      end else if (seq == 12 || seq == 40) begin
        // sender pauses until every drip byte is back
        req_if.valid <= 1'b0;
        wait (drip_q.size() == 0);
        @(negedge clk_i);
      end else if (choice < 82) begin
        // well-formed: optional init, absorb bytes, stops, sometimes more absorb bytes, then drips
        if ($urandom_range(0, 1)) send_rand(REQ_INIT);
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       nb = 63;
            1:       nb = 64;
            2:       nb = 65;
            default: nb = $urandom_range(56, 72);
          endcase
        end else begin
          nb = $urandom_range(0, 10);
        end
        repeat (nb) send_rand(REQ_ABSORB);
        repeat ($urandom_range(0, 2)) send_rand(REQ_STOP);
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_rand(REQ_ABSORB);
        repeat ($urandom_range(1, 12)) send_rand(REQ_DRIP);
      end else begin
        // noise: any request in any order
        repeat ($urandom_range(1, 6)) send_rand(req_e'($urandom_range(0, 3)));
      end
    end

    // drain
    req_if.valid <= 1'b0;
    wait (drip_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
